// ===== rtl/core/hezc_pkg.sv =====
// Shared constants, types, a saturation helper and a sign test for the Hermite edge zero crossing core.
// No dependencies; imported by every module in rtl/core.
package hezc_pkg;

	localparam int IN_W             = 32;
	localparam int FRAC_BITS        = 16;
	localparam int FRAC_W           = 17;
	localparam int VALUE_WIDTH_DEF  = 32;
	localparam int BISECT_STEPS_DEF = 10;
	localparam int WIDE_W           = 128;
	localparam int CUBIC_LAT        = 3;

	localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
	localparam logic [FRAC_W-1:0] FRAC_HALF = 17'd32768;

	typedef logic signed [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic vld;
		logic eq;
		logic mid;
	} ctl_t;

	// clamp to a signed w-bit range
	function automatic wide_t sat_w(input wide_t x, input int w);
		wide_t hi;
		wide_t lo;
		hi = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
		lo = -hi - wide_t'(1);
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	// the bracket end at l and the probe at v straddle zero
	function automatic logic sign_flip(input wide_t l, input wide_t v);
		return (l < 0 && v >= 0) || (l > 0 && v <= 0);
	endfunction

endpackage

// ===== rtl/core/hezc_cubic.sv =====
// Pipelined Horner evaluation of a*s^3 + b*s^2 + c*s + d, one probe per cycle.
// Depends on hezc_pkg; the probe passes the registers m1_s1, m2_s2 and m3_s3 in turn and f is combinational from m3_s3.
module hezc_cubic import hezc_pkg::*; #(
	parameter int W = VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic [FRAC_W-1:0]   s,
	input  logic signed [W-1:0] a,
	input  logic signed [W-1:0] b,
	input  logic signed [W-1:0] c,
	input  logic signed [W-1:0] d,
	output logic signed [W-1:0] f,
	output logic signed [W-1:0] a_o,
	output logic signed [W-1:0] b_o,
	output logic signed [W-1:0] c_o,
	output logic signed [W-1:0] d_o
);

	localparam int PW = W + FRAC_W + 1;

	logic signed [PW-1:0] p1, p2, p3;
	logic signed [W-1:0]  t2, t3;
	logic signed [W-1:0]  m1_s1, m2_s2, m3_s3;
	logic [FRAC_W-1:0]    s_s1, s_s2;
	logic signed [W-1:0]  a_s1, b_s1, c_s1, d_s1;
	logic signed [W-1:0]  a_s2, b_s2, c_s2, d_s2;
	logic signed [W-1:0]  a_s3, b_s3, c_s3, d_s3;

	assign p1 = a * $signed({1'b0, s});
	assign t2 = W'(sat_w(wide_t'(m1_s1) + wide_t'(b_s1), W));
	assign p2 = t2 * $signed({1'b0, s_s1});
	assign t3 = W'(sat_w(wide_t'(m2_s2) + wide_t'(c_s2), W));
	assign p3 = t3 * $signed({1'b0, s_s2});

	always_ff @(posedge clk) begin
		m1_s1 <= W'(sat_w(wide_t'(p1) >>> FRAC_BITS, W));
		m2_s2 <= W'(sat_w(wide_t'(p2) >>> FRAC_BITS, W));
		m3_s3 <= W'(sat_w(wide_t'(p3) >>> FRAC_BITS, W));
		s_s1  <= s;
		s_s2  <= s_s1;
		a_s1  <= a;
		b_s1  <= b;
		c_s1  <= c;
		d_s1  <= d;
		a_s2  <= a_s1;
		b_s2  <= b_s1;
		c_s2  <= c_s1;
		d_s2  <= d_s1;
		a_s3  <= a_s2;
		b_s3  <= b_s2;
		c_s3  <= c_s2;
		d_s3  <= d_s2;
	end

	assign f   = W'(sat_w(wide_t'(m3_s3) + wide_t'(d_s3), W));
	assign a_o = a_s3;
	assign b_o = b_s3;
	assign c_o = c_s3;
	assign d_o = d_s3;

endmodule

// ===== rtl/core/hezc_bisect_cell.sv =====
// One bisection step: probe the bracket midpoint, keep the half that holds the crossing.
// Depends on hezc_pkg and hezc_cubic; all outputs are registered.
module hezc_bisect_cell import hezc_pkg::*; #(
	parameter int W = VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_t                ctl_i,
	input  logic [FRAC_W-1:0]   sl_i,
	input  logic [FRAC_W-1:0]   sr_i,
	input  logic signed [W-1:0] vl_i,
	input  logic signed [W-1:0] a_i,
	input  logic signed [W-1:0] b_i,
	input  logic signed [W-1:0] c_i,
	input  logic signed [W-1:0] d_i,
	output ctl_t                ctl_o,
	output logic [FRAC_W-1:0]   sl_o,
	output logic [FRAC_W-1:0]   sr_o,
	output logic signed [W-1:0] vl_o,
	output logic signed [W-1:0] a_o,
	output logic signed [W-1:0] b_o,
	output logic signed [W-1:0] c_o,
	output logic signed [W-1:0] d_o
);

	logic [FRAC_W-1:0]   m;
	logic signed [W-1:0] fm, ca, cb, cc, cd;
	logic                flip;
	ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [FRAC_W-1:0]   sl_s1, sl_s2, sl_s3, sl_s4;
	logic [FRAC_W-1:0]   sr_s1, sr_s2, sr_s3, sr_s4;
	logic [FRAC_W-1:0]   m_s1, m_s2, m_s3;
	logic signed [W-1:0] vl_s1, vl_s2, vl_s3, vl_s4;
	logic signed [W-1:0] a_s4, b_s4, c_s4, d_s4;

	assign m = FRAC_W'(({1'b0, sl_i} + {1'b0, sr_i}) >> 1);

	hezc_cubic #(.W(W)) u_cubic (
		.clk (clk),
		.s   (m),
		.a   (a_i),
		.b   (b_i),
		.c   (c_i),
		.d   (d_i),
		.f   (fm),
		.a_o (ca),
		.b_o (cb),
		.c_o (cc),
		.d_o (cd)
	);

	assign flip = sign_flip(wide_t'(vl_s3), wide_t'(fm));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		sl_s1 <= sl_i;
		sr_s1 <= sr_i;
		vl_s1 <= vl_i;
		m_s1  <= m;
		sl_s2 <= sl_s1;
		sr_s2 <= sr_s1;
		vl_s2 <= vl_s1;
		m_s2  <= m_s1;
		sl_s3 <= sl_s2;
		sr_s3 <= sr_s2;
		vl_s3 <= vl_s2;
		m_s3  <= m_s2;
		// crossing in the left half: pull the right end in, else advance the left end
		if (flip) begin
			sl_s4 <= sl_s3;
			sr_s4 <= m_s3;
			vl_s4 <= vl_s3;
		end else begin
			sl_s4 <= m_s3;
			sr_s4 <= sr_s3;
			vl_s4 <= fm;
		end
		a_s4 <= ca;
		b_s4 <= cb;
		c_s4 <= cc;
		d_s4 <= cd;
	end

	assign ctl_o = ctl_s4;
	assign sl_o  = sl_s4;
	assign sr_o  = sr_s4;
	assign vl_o  = vl_s4;
	assign a_o   = a_s4;
	assign b_o   = b_s4;
	assign c_o   = c_s4;
	assign d_o   = d_s4;

endmodule

// ===== rtl/core/hermite_edge_zero_crossing.sv =====
// Top level: Hermite cubic along a mesh edge, extremum bracketing and a chain of bisection cells.
// Depends on hezc_pkg, hezc_cubic and hezc_bisect_cell.
//
//  channel   handshake       payload
//  --------  --------------  ---------------------------------------------------------
//  command   start / busy    value_start, value_end, edge_d*, grad_start_*, grad_end_*
//  result    done            crossing_fraction, middle_root_used
//
// One word is taken every cycle; busy stays low. Each word leaves on done after passing
// the front stages, the square root stages (one root bit each), the 17 divider stages,
// the extremum cubics, the bracket register, the bisection cells and the result register.
// Reset clears the valid and control flags and the car_t words that carry them.
// The result is shown for one cycle and is not held.
module hermite_edge_zero_crossing import hezc_pkg::*; #(
	parameter int BISECT_STEPS = BISECT_STEPS_DEF,
	parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [IN_W-1:0]  value_start,
	input  logic signed [IN_W-1:0]  value_end,
	input  logic signed [IN_W-1:0]  edge_dx,
	input  logic signed [IN_W-1:0]  edge_dy,
	input  logic signed [IN_W-1:0]  edge_dz,
	input  logic signed [IN_W-1:0]  grad_start_x,
	input  logic signed [IN_W-1:0]  grad_start_y,
	input  logic signed [IN_W-1:0]  grad_start_z,
	input  logic signed [IN_W-1:0]  grad_end_x,
	input  logic signed [IN_W-1:0]  grad_end_y,
	input  logic signed [IN_W-1:0]  grad_end_z,
	output logic                    done,
	output logic [FRAC_W-1:0]       crossing_fraction,
	output logic                    middle_root_used
);

	localparam int W   = VALUE_WIDTH;
	localparam int N   = BISECT_STEPS;
	localparam int RB  = (W + 16) / 2;
	localparam int TW  = 2 * RB + 2;
	localparam int UW  = W + 2;
	localparam int RW  = UW + 1;
	localparam int LAT = 5 + RB + (FRAC_BITS + 1) + CUBIC_LAT + 1 + (CUBIC_LAT + 1) * N + 1;

	typedef struct packed {
		logic                vld;
		logic                eq;
		logic                ok;
		logic signed [W-1:0] a;
		logic signed [W-1:0] b;
		logic signed [W-1:0] c;
		logic signed [W-1:0] d;
	} car_t;

	typedef struct packed {
		logic                 z;
		logic                 e;
		logic                 f;
		logic [RW-1:0]        rem;
		logic [UW-1:0]        ud;
		logic [FRAC_BITS-1:0] q;
	} rt_t;

	// set up n/den for a fraction in [0,1]
	function automatic rt_t ratio_init(input wide_t n, input wide_t den);
		rt_t   r;
		wide_t un;
		wide_t ud;
		un    = (n < 0) ? -n : n;
		ud    = (den < 0) ? -den : den;
		r.z   = (n == 0);
		r.e   = !r.z && (un == ud);
		r.f   = !r.z && (((n < 0) != (den < 0)) || (un > ud));
		r.rem = RW'(un);
		r.ud  = UW'(ud);
		r.q   = '0;
		return r;
	endfunction

	// one restoring quotient bit
	function automatic rt_t div_step(input rt_t x);
		rt_t           r;
		logic [RW-1:0] rem2;
		logic          ge;
		r    = x;
		rem2 = {x.rem[RW-2:0], 1'b0};
		ge   = rem2 >= RW'(x.ud);
		r.rem = ge ? rem2 - RW'(x.ud) : rem2;
		r.q   = {x.q[FRAC_BITS-2:0], ge};
		return r;
	endfunction

	function automatic logic [FRAC_W-1:0] ratio_value(input rt_t x);
		if (x.z)
			return '0;
		if (x.e)
			return FRAC_ONE;
		return {1'b0, x.q};
	endfunction

	// ---- front: saturate, dot products, coefficients, discriminant ----
	logic                   vld_s1, eq_s1, vld_s2, eq_s2;
	logic signed [W-1:0]    v0_s1, v1_s1, v0_s2, v1_s2, d0_s2, d1_s2;
	logic signed [2*IN_W-1:0] pr_s1 [6];
	car_t                   car_s3, car_s4, car_s5;
	logic signed [2*W-1:0]  pbb, pac;
	logic signed [W-1:0]    bb_s4, ac_s4, disc_s5;
	wide_t                  sum0, sum1, av, bv, dv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		eq_s1    <= (value_start == value_end);
		v0_s1    <= W'(sat_w(wide_t'(value_start), W));
		v1_s1    <= W'(sat_w(wide_t'(value_end), W));
		pr_s1[0] <= edge_dx * grad_start_x;
		pr_s1[1] <= edge_dy * grad_start_y;
		pr_s1[2] <= edge_dz * grad_start_z;
		pr_s1[3] <= edge_dx * grad_end_x;
		pr_s1[4] <= edge_dy * grad_end_y;
		pr_s1[5] <= edge_dz * grad_end_z;
	end

	assign sum0 = wide_t'(pr_s1[0]) + wide_t'(pr_s1[1]) + wide_t'(pr_s1[2]);
	assign sum1 = wide_t'(pr_s1[3]) + wide_t'(pr_s1[4]) + wide_t'(pr_s1[5]);

	always_ff @(posedge clk) begin
		eq_s2 <= eq_s1;
		v0_s2 <= v0_s1;
		v1_s2 <= v1_s1;
		d0_s2 <= W'(sat_w(sum0 >>> FRAC_BITS, W));
		d1_s2 <= W'(sat_w(sum1 >>> FRAC_BITS, W));
	end

	assign av = wide_t'(2) * (wide_t'(v0_s2) - wide_t'(v1_s2)) + wide_t'(d0_s2) + wide_t'(d1_s2);
	assign bv = wide_t'(3) * (wide_t'(v1_s2) - wide_t'(v0_s2)) - wide_t'(2) * wide_t'(d0_s2)
		- wide_t'(d1_s2);
	assign pbb = car_s3.b * car_s3.b;
	assign pac = car_s3.a * car_s3.c;
	assign dv  = wide_t'(4) * wide_t'(bb_s4) - wide_t'(12) * wide_t'(ac_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			car_s3 <= '0;
			car_s4 <= '0;
			car_s5 <= '0;
		end else begin
			car_s3.vld <= vld_s2;
			car_s3.eq  <= eq_s2;
			car_s3.ok  <= 1'b0;
			car_s3.a   <= W'(sat_w(av, W));
			car_s3.b   <= W'(sat_w(bv, W));
			car_s3.c   <= d0_s2;
			car_s3.d   <= v0_s2;
			car_s4     <= car_s3;
			car_s5     <= '{vld: car_s4.vld, eq: car_s4.eq,
				ok: (sat_w(dv, W) > 0) && (car_s4.a != '0),
				a: car_s4.a, b: car_s4.b, c: car_s4.c, d: car_s4.d};
		end
	end

	always_ff @(posedge clk) begin
		bb_s4   <= W'(sat_w(wide_t'(pbb) >>> FRAC_BITS, W));
		ac_s4   <= W'(sat_w(wide_t'(pac) >>> FRAC_BITS, W));
		disc_s5 <= W'(sat_w(dv, W));
	end

	// ---- square root of disc * 2^16, one root bit per stage ----
	car_t            sq_car  [0:RB];
	logic [TW-1:0]   sq_rem  [0:RB];
	logic [RB-1:0]   sq_root [0:RB];

	assign sq_car[0]  = car_s5;
	assign sq_rem[0]  = TW'({disc_s5, 16'h0});
	assign sq_root[0] = '0;

	for (genvar j = 0; j < RB; j++) begin : g_sqrt
		localparam int I = RB - 1 - j;
		logic [TW-1:0] trial;
		logic          take;

		assign trial = (TW'(sq_root[j]) << (I + 1)) + (TW'(1) << (2 * I));
		assign take  = sq_rem[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_car[j+1] <= '0;
			else
				sq_car[j+1] <= sq_car[j];
		end

		always_ff @(posedge clk) begin
			sq_rem[j+1]  <= take ? sq_rem[j] - trial : sq_rem[j];
			sq_root[j+1] <= take ? (sq_root[j] | (RB'(1) << I)) : sq_root[j];
		end
	end

	// ---- extrema (-2b +- sqrt) / 6a, one quotient bit per stage ----
	car_t  dv_car [0:FRAC_BITS];
	rt_t   dv_r1  [0:FRAC_BITS];
	rt_t   dv_r2  [0:FRAC_BITS];
	wide_t nb, sqv, den;

	assign nb  = -wide_t'(2) * wide_t'(sq_car[RB].b);
	assign sqv = wide_t'(sq_root[RB]);
	assign den = wide_t'(6) * wide_t'(sq_car[RB].a);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_car[0] <= '0;
		else
			dv_car[0] <= sq_car[RB];
	end

	always_ff @(posedge clk) begin
		dv_r1[0] <= ratio_init(nb + sqv, den);
		dv_r2[0] <= ratio_init(nb - sqv, den);
	end

	for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_car[j+1] <= '0;
			else
				dv_car[j+1] <= dv_car[j];
		end

		always_ff @(posedge clk) begin
			dv_r1[j+1] <= div_step(dv_r1[j]);
			dv_r2[j+1] <= div_step(dv_r2[j]);
		end
	end

	// ---- cubic at both extrema ----
	car_t                cb_car [0:CUBIC_LAT];
	logic [FRAC_W-1:0]   cb_r1  [0:CUBIC_LAT];
	logic [FRAC_W-1:0]   cb_r2  [0:CUBIC_LAT];
	logic signed [W-1:0] f1, f2;

	always_comb begin
		cb_car[0]    = dv_car[FRAC_BITS];
		cb_car[0].ok = dv_car[FRAC_BITS].ok && !dv_r1[FRAC_BITS].f && !dv_r2[FRAC_BITS].f;
	end
	assign cb_r1[0] = ratio_value(dv_r1[FRAC_BITS]);
	assign cb_r2[0] = ratio_value(dv_r2[FRAC_BITS]);

	for (genvar j = 0; j < CUBIC_LAT; j++) begin : g_cbdly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				cb_car[j+1] <= '0;
			else
				cb_car[j+1] <= cb_car[j];
		end

		always_ff @(posedge clk) begin
			cb_r1[j+1] <= cb_r1[j];
			cb_r2[j+1] <= cb_r2[j];
		end
	end

	hezc_cubic #(.W(W)) u_cubic_r1 (
		.clk (clk),
		.s   (cb_r1[0]),
		.a   (cb_car[0].a),
		.b   (cb_car[0].b),
		.c   (cb_car[0].c),
		.d   (cb_car[0].d),
		.f   (f1),
		.a_o (),
		.b_o (),
		.c_o (),
		.d_o ()
	);

	hezc_cubic #(.W(W)) u_cubic_r2 (
		.clk (clk),
		.s   (cb_r2[0]),
		.a   (cb_car[0].a),
		.b   (cb_car[0].b),
		.c   (cb_car[0].c),
		.d   (cb_car[0].d),
		.f   (f2),
		.a_o (),
		.b_o (),
		.c_o (),
		.d_o ()
	);

	// ---- initial bracket ----
	logic                narrow;
	ctl_t                br_ctl_q;
	logic [FRAC_W-1:0]   br_sl_q, br_sr_q;
	logic signed [W-1:0] br_vl_q, br_a_q, br_b_q, br_c_q, br_d_q;

	assign narrow = cb_car[CUBIC_LAT].ok && sign_flip(wide_t'(f1), wide_t'(f2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_ctl_q <= '0;
		end else begin
			br_ctl_q.vld <= cb_car[CUBIC_LAT].vld;
			br_ctl_q.eq  <= cb_car[CUBIC_LAT].eq;
			br_ctl_q.mid <= narrow;
		end
	end

	always_ff @(posedge clk) begin
		br_a_q <= cb_car[CUBIC_LAT].a;
		br_b_q <= cb_car[CUBIC_LAT].b;
		br_c_q <= cb_car[CUBIC_LAT].c;
		br_d_q <= cb_car[CUBIC_LAT].d;
		if (!narrow) begin
			br_sl_q <= '0;
			br_sr_q <= FRAC_ONE;
			br_vl_q <= cb_car[CUBIC_LAT].d;
		end else if (cb_r1[CUBIC_LAT] < cb_r2[CUBIC_LAT]) begin
			br_sl_q <= cb_r1[CUBIC_LAT];
			br_sr_q <= cb_r2[CUBIC_LAT];
			br_vl_q <= f1;
		end else begin
			br_sl_q <= cb_r2[CUBIC_LAT];
			br_sr_q <= cb_r1[CUBIC_LAT];
			br_vl_q <= f2;
		end
	end

	// ---- bisection chain ----
	ctl_t                ch_ctl [0:N];
	logic [FRAC_W-1:0]   ch_sl  [0:N];
	logic [FRAC_W-1:0]   ch_sr  [0:N];
	logic signed [W-1:0] ch_vl  [0:N];
	logic signed [W-1:0] ch_a   [0:N];
	logic signed [W-1:0] ch_b   [0:N];
	logic signed [W-1:0] ch_c   [0:N];
	logic signed [W-1:0] ch_d   [0:N];

	assign ch_ctl[0] = br_ctl_q;
	assign ch_sl[0]  = br_sl_q;
	assign ch_sr[0]  = br_sr_q;
	assign ch_vl[0]  = br_vl_q;
	assign ch_a[0]   = br_a_q;
	assign ch_b[0]   = br_b_q;
	assign ch_c[0]   = br_c_q;
	assign ch_d[0]   = br_d_q;

	for (genvar k = 0; k < N; k++) begin : g_cell
		hezc_bisect_cell #(.W(W)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  (ch_ctl[k]),
			.sl_i   (ch_sl[k]),
			.sr_i   (ch_sr[k]),
			.vl_i   (ch_vl[k]),
			.a_i    (ch_a[k]),
			.b_i    (ch_b[k]),
			.c_i    (ch_c[k]),
			.d_i    (ch_d[k]),
			.ctl_o  (ch_ctl[k+1]),
			.sl_o   (ch_sl[k+1]),
			.sr_o   (ch_sr[k+1]),
			.vl_o   (ch_vl[k+1]),
			.a_o    (ch_a[k+1]),
			.b_o    (ch_b[k+1]),
			.c_o    (ch_c[k+1]),
			.d_o    (ch_d[k+1])
		);
	end

	// ---- result word ----
	logic [FRAC_W-1:0] mid_pt;
	logic              done_q, middle_root_used_q;
	logic [FRAC_W-1:0] crossing_fraction_q;

	assign mid_pt = FRAC_W'(({1'b0, ch_sl[N]} + {1'b0, ch_sr[N]}) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q             <= 1'b0;
			middle_root_used_q <= 1'b0;
		end else begin
			done_q             <= ch_ctl[N].vld;
			middle_root_used_q <= ch_ctl[N].vld && !ch_ctl[N].eq && ch_ctl[N].mid;
		end
	end

	// equal end values bypass the search result
	always_ff @(posedge clk) begin
		crossing_fraction_q <= ch_ctl[N].eq ? FRAC_HALF : mid_pt;
	end

	assign busy              = 1'b0;
	assign done              = done_q;
	assign crossing_fraction = crossing_fraction_q;
	assign middle_root_used  = middle_root_used_q;

`ifndef SYNTH
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("result word without a command word LAT cycles earlier");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> crossing_fraction <= FRAC_ONE)
		else $error("crossing fraction beyond the edge end");

	a_mid_flag: assert property (@(posedge clk) disable iff (!arst_n)
		middle_root_used |-> done)
		else $error("middle root flag outside a result word");
`endif

endmodule
